FILE: rtl/htpd_pkg.sv
// Package: frame sync constants, parser positions and event codes for the deframer.
`timescale 1ns / 1ps

package htpd_pkg;

  localparam logic [7:0] SYNC_H1 = 8'hAB;
  localparam logic [7:0] SYNC_H2 = 8'hCD;
  localparam logic [7:0] SYNC_T1 = 8'hE1;
  localparam logic [7:0] SYNC_T2 = 8'hE2;

  typedef enum logic [2:0] {
    POS_H1   = 3'd0,
    POS_H2   = 3'd1,
    POS_CMD  = 3'd2,
    POS_LEN  = 3'd3,
    POS_DATA = 3'd4,
    POS_T1   = 3'd5,
    POS_T2   = 3'd6
  } pos_e;

  typedef enum logic [2:0] {
    EV_BUSY   = 3'd0,
    EV_DATA   = 3'd1,
    EV_OK     = 3'd2,
    EV_BAD_H1 = 3'd3,
    EV_BAD_H2 = 3'd4,
    EV_BAD_T1 = 3'd5,
    EV_BAD_T2 = 3'd6
  } ev_e;

endpackage

FILE: rtl/header_trailer_packet_deframer.sv
// Top level: byte-serial frame parser (AB CD cmd len payload E1 E2) with one result per byte.
//
//   channel  handshake                    payload
//   input    in_valid_i / in_ready_o      rx_byte_i
//   output   out_valid_o / out_ready_i    event_res_o, payload_byte_o, payload_index_o,
//                                         frame_command_o, frame_length_o
//
// One byte per cycle unless stalled; each byte passes the input, then the result register.
// The parse state updates as a byte moves from the input register to the result register.
// A stalled result holds; the input register still takes one more byte, then ready drops.
// Reset returns the parser to hunting for the first header byte, held fields cleared.
`timescale 1ns / 1ps

module header_trailer_packet_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_res_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic [7:0] frame_command_o,
  output logic [7:0] frame_length_o
);
  import htpd_pkg::*;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // parser state
  pos_e       pos_q, pos_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [7:0] idx_q, idx_d;

  // result register
  logic       out_vld_q;
  ev_e        ev_q, ev_d;
  logic [7:0] pb_q, pb_d;
  logic [7:0] pi_q, pi_d;

  logic       adv;
  logic       last_data;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign last_data  = ({1'b0, idx_q} + 9'd1) >= {1'b0, len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // next parser state
  always_comb begin
    pos_d = pos_q;
    cmd_d = cmd_q;
    len_d = len_q;
    idx_d = idx_q;
    unique case (pos_q)
      POS_H2: begin
        pos_d = (in_byte_q == SYNC_H2) ? POS_CMD : POS_H1;
      end
      POS_CMD: begin
        cmd_d = in_byte_q;
        pos_d = POS_LEN;
      end
      POS_LEN: begin
        len_d = in_byte_q;
        idx_d = 8'd0;
        pos_d = (in_byte_q == 8'd0) ? POS_T1 : POS_DATA;
      end
      POS_DATA: begin
        if (last_data) begin
          idx_d = 8'd0;
          pos_d = POS_T1;
        end else begin
          idx_d = idx_q + 8'd1;
        end
      end
      POS_T1: begin
        pos_d = (in_byte_q == SYNC_T1) ? POS_T2 : POS_H1;
      end
      POS_T2: begin
        pos_d = POS_H1;
      end
      default: begin  // hunting, and the unused code
        pos_d = (in_byte_q == SYNC_H1) ? POS_H2 : POS_H1;
      end
    endcase
  end

  // result for the byte in the input register
  always_comb begin
    ev_d = EV_BUSY;
    pb_d = 8'd0;
    pi_d = 8'd0;
    unique case (pos_q)
      POS_H2: begin
        if (in_byte_q != SYNC_H2) ev_d = EV_BAD_H2;
      end
      POS_CMD, POS_LEN: begin
        ev_d = EV_BUSY;
      end
      POS_DATA: begin
        ev_d = EV_DATA;
        pb_d = in_byte_q;
        pi_d = idx_q;
      end
      POS_T1: begin
        if (in_byte_q != SYNC_T1) ev_d = EV_BAD_T1;
      end
      POS_T2: begin
        ev_d = (in_byte_q == SYNC_T2) ? EV_OK : EV_BAD_T2;
      end
      default: begin
        if (in_byte_q != SYNC_H1) ev_d = EV_BAD_H1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_H1;
      cmd_q <= 8'd0;
      len_q <= 8'd0;
      idx_q <= 8'd0;
    end else if (adv) begin
      pos_q <= pos_d;
      cmd_q <= cmd_d;
      len_q <= len_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ev_q <= ev_d;
      pb_q <= pb_d;
      pi_q <= pi_d;
    end
  end

  // held fields already reflect the byte now in the result register
  assign out_valid_o     = out_vld_q;
  assign event_res_o     = ev_q;
  assign payload_byte_o  = pb_q;
  assign payload_index_o = pi_q;
  assign frame_command_o = cmd_q;
  assign frame_length_o  = len_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == POS_DATA |-> idx_q < len_q)
    else $error("payload index past frame length");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("request advanced but no result registered");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages full and stalled");

  a_t2_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && pos_q == POS_T2 |=> pos_q == POS_H1)
    else $error("parser did not return to hunting after second trailer");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && pos_q == POS_LEN && in_byte_q == 8'd0 |=> pos_q == POS_T1)
    else $error("zero length did not skip to trailer");

endmodule
